// ----- design/psu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_pkg
// shared types and codes for the priority stack unit and its cell chain
// ----------------------------------------------------------------------------
package psu_pkg;

  // command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // error codes returned with each result word
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e_t;

  // width of the count output
  localparam int COUNT_BITS = 5;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

// ----- design/psu_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_cell
// one slot of the sorted chain: holds an element and its priority
// ----------------------------------------------------------------------------
module psu_cell #(
  parameter int IDX       = 0,
  parameter int CNT_W     = 5,
  parameter int ELEM_BITS = 32,
  parameter int PRIO_BITS = 8
) (
  input  logic                   clk,
  input  psu_pkg::cell_ctrl_t    ctrl,
  input  logic [CNT_W-1:0]       fill,
  input  logic [ELEM_BITS-1:0]   new_elem,
  input  logic [PRIO_BITS-1:0]   new_prio,
  input  logic                   left_take,
  input  logic [ELEM_BITS-1:0]   left_elem,
  input  logic [PRIO_BITS-1:0]   left_prio,
  input  logic [ELEM_BITS-1:0]   right_elem,
  input  logic [PRIO_BITS-1:0]   right_prio,
  output logic                   take,
  output logic [ELEM_BITS-1:0]   elem,
  output logic [PRIO_BITS-1:0]   prio
);

  logic occupied;

  // slot is in use when it lies below the fill level
  assign occupied = fill > CNT_W'(IDX);

  // new word belongs at or before this slot
  assign take = !occupied || (prio <= new_prio);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (left_take) begin
        elem <= left_elem;
        prio <= left_prio;
      end else if (take) begin
        elem <= new_elem;
        prio <= new_prio;
      end
    end else if (ctrl.pop) begin
      elem <= right_elem;
      prio <= right_prio;
    end
  end

endmodule

// ----- design/priority_stack_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_stack_unit
// sorted priority store with newest-first order among equal priorities
// ----------------------------------------------------------------------------
// The store is a row of DEPTH cells kept sorted by descending priority, the
// head in cell 0. A push word inserts its element in front of the first entry
// whose priority is less than or equal to its own (so equal priorities behave
// as a stack); a pop word removes the head. Every accepted word returns one
// result word with the head element and priority, the count, an empty flag
// and an error code, all describing the store after the command. A pop on an
// empty store and a push on a full store change nothing and are flagged.
// Throughput is one command per clock: each cell decides locally from a
// single priority compare and its left neighbor's decision whether to keep,
// load the new word or take its neighbor's entry, so there is no ripple
// along the chain. The result is ready in the cycle after acceptance and
// input is stalled only while that result word is itself stalled.
module priority_stack_unit #(
  parameter int DEPTH     = 16,
  parameter int ELEM_BITS = 32,
  parameter int PRIO_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  // command channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic [ELEM_BITS-1:0]             elem,
  input  logic [PRIO_BITS-1:0]             prio,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ELEM_BITS-1:0]             head_elem,
  output logic [PRIO_BITS-1:0]             head_prio,
  output logic [psu_pkg::COUNT_BITS-1:0]   count,
  output logic                             is_empty,
  output logic [1:0]                       error
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // chain wiring, the boundary ties are made per cell below
  logic [ELEM_BITS-1:0] cell_elem [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio [DEPTH];
  logic [DEPTH-1:0]     cell_take;

  logic [CNT_W-1:0]     fill;
  logic [CNT_W-1:0]     fill_next;
  psu_pkg::err_e_t      err;
  psu_pkg::err_e_t      err_next;
  logic                 out_valid_next;
  logic                 accept;
  logic                 is_full;
  logic                 none;
  psu_pkg::cell_ctrl_t  ctrl;

  // a new word is taken unless the pending result is held back
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign none    = fill == '0;
  assign is_full = fill == CNT_W'(DEPTH);

  // decode the command and screen out the empty and full cases
  always_comb begin
    ctrl.push = 1'b0;
    ctrl.pop  = 1'b0;
    fill_next = fill;
    err_next  = err;
    if (accept) begin
      err_next = psu_pkg::ERR_OK;
      if (cmd == psu_pkg::CMD_PUSH) begin
        if (is_full) begin
          err_next = psu_pkg::ERR_FULL;
        end else begin
          ctrl.push = 1'b1;
          fill_next = fill + 1'b1;
        end
      end else begin
        if (none) begin
          err_next = psu_pkg::ERR_EMPTY;
        end else begin
          ctrl.pop  = 1'b1;
          fill_next = fill - 1'b1;
        end
      end
    end
  end

  // result word is valid the cycle after a command and held while stalled
  always_comb begin
    out_valid_next = out_valid;
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      err       <= psu_pkg::ERR_OK;
      out_valid <= 1'b0;
    end else begin
      fill      <= fill_next;
      err       <= err_next;
      out_valid <= out_valid_next;
    end
  end

  // row of cells, cell 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 left_take;
    logic [ELEM_BITS-1:0] left_elem;
    logic [PRIO_BITS-1:0] left_prio;
    logic [ELEM_BITS-1:0] right_elem;
    logic [PRIO_BITS-1:0] right_prio;

    if (i == 0) begin : g_head
      assign left_take = 1'b0;
      assign left_elem = '0;
      assign left_prio = '0;
    end else begin : g_mid
      assign left_take = cell_take[i-1];
      assign left_elem = cell_elem[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_elem = '0;
      assign right_prio = '0;
    end else begin : g_body
      assign right_elem = cell_elem[i+1];
      assign right_prio = cell_prio[i+1];
    end

    psu_cell #(
      .IDX       (i),
      .CNT_W     (CNT_W),
      .ELEM_BITS (ELEM_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .fill       (fill),
      .new_elem   (elem),
      .new_prio   (prio),
      .left_take  (left_take),
      .left_elem  (left_elem),
      .left_prio  (left_prio),
      .right_elem (right_elem),
      .right_prio (right_prio),
      .take       (cell_take[i]),
      .elem       (cell_elem[i]),
      .prio       (cell_prio[i])
    );
  end

  // result fields read straight from the store, which cannot move while
  // the result word is pending
  assign is_empty  = none;
  assign head_elem = none ? '0 : cell_elem[0];
  assign head_prio = none ? '0 : cell_prio[0];
  assign count     = psu_pkg::COUNT_BITS'(fill);
  assign error     = err;

endmodule

// ----- design/psu_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_check
// port-level checks for the priority stack unit
// ----------------------------------------------------------------------------
module psu_check #(
  parameter int ELEM_BITS = 32,
  parameter int PRIO_BITS = 8
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ELEM_BITS-1:0]           head_elem,
  input logic [PRIO_BITS-1:0]           head_prio,
  input logic [psu_pkg::COUNT_BITS-1:0] count,
  input logic                           is_empty,
  input logic [1:0]                     error
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(head_elem) && $stable(count))
    else $error("stalled result word changed");

  // input only stalls behind a stalled result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending result");

  // accepted command always yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word produced no result");

  // empty flag agrees with count and zero head
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> count == '0 && head_elem == '0 && head_prio == '0)
    else $error("empty result with nonzero fields");

  // pop on empty only reported for an empty store
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && error == psu_pkg::ERR_EMPTY |-> is_empty)
    else $error("empty error on a nonempty store");

endmodule

bind priority_stack_unit psu_check #(
  .ELEM_BITS (ELEM_BITS),
  .PRIO_BITS (PRIO_BITS)
) u_psu_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .head_elem (head_elem),
  .head_prio (head_prio),
  .count     (count),
  .is_empty  (is_empty),
  .error     (error)
);

// ----- sim/stack_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_checker
// watches both word channels of the priority stack unit, keeps its own
// sorted copy of the store and compares every result word with the head,
// count and error code that the copy predicts
// ----------------------------------------------------------------------------
module stack_checker #(
  parameter int DEPTH     = 16,
  parameter int ELEM_BITS = 32,
  parameter int PRIO_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           cmd,
  input  logic [ELEM_BITS-1:0]           elem,
  input  logic [PRIO_BITS-1:0]           prio,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [ELEM_BITS-1:0]           head_elem,
  input  logic [PRIO_BITS-1:0]           head_prio,
  input  logic [psu_pkg::COUNT_BITS-1:0] count,
  input  logic                           is_empty,
  input  logic [1:0]                     error,
  output int                             fail_count,
  output int                             pending
);
  import psu_pkg::*;

  typedef struct {
    logic [ELEM_BITS-1:0]  head_elem;
    logic [PRIO_BITS-1:0]  head_prio;
    logic [COUNT_BITS-1:0] count;
    logic                  is_empty;
    err_e_t                error;
  } head_report_t;

  // shadow store, slot 0 is the head
  logic [ELEM_BITS-1:0] slot_elem [DEPTH];
  logic [PRIO_BITS-1:0] slot_prio [DEPTH];
  int                   used_slots;
  head_report_t         expected_heads [$];

  // apply one command to the shadow store and report the head afterwards
  function automatic head_report_t apply_command(logic c, logic [ELEM_BITS-1:0] e,
                                                 logic [PRIO_BITS-1:0] p);
    head_report_t r;
    int           pos;
    r.error = ERR_OK;
    if (c == CMD_PUSH) begin
      if (used_slots >= DEPTH) begin
        r.error = ERR_FULL;
      end else begin
        // in front of the first entry with priority <= p, so ties go newest first
        pos = 0;
        while (pos < used_slots && slot_prio[pos] > p) pos++;
        for (int i = used_slots; i > pos; i--) begin
          slot_elem[i] = slot_elem[i-1];
          slot_prio[i] = slot_prio[i-1];
        end
        slot_elem[pos] = e;
        slot_prio[pos] = p;
        used_slots++;
      end
    end else begin
      if (used_slots == 0) begin
        r.error = ERR_EMPTY;
      end else begin
        for (int i = 0; i + 1 < used_slots; i++) begin
          slot_elem[i] = slot_elem[i+1];
          slot_prio[i] = slot_prio[i+1];
        end
        used_slots--;
      end
    end
    r.is_empty  = (used_slots == 0);
    r.head_elem = r.is_empty ? '0 : slot_elem[0];
    r.head_prio = r.is_empty ? '0 : slot_prio[0];
    r.count     = COUNT_BITS'(used_slots);
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    used_slots = 0;
  end

  always @(posedge clk) begin
    head_report_t want;
    if (rst) begin
      used_slots = 0;
      expected_heads.delete();
    end else begin
      // result words always belong to earlier commands, so check before predicting
      if (out_valid && !out_stall) begin
        if (expected_heads.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          want = expected_heads.pop_front();
          if (head_elem !== want.head_elem) begin
            $error("head_elem: expected %0h, got %0h", want.head_elem, head_elem);
            fail_count++;
          end
          if (head_prio !== want.head_prio) begin
            $error("head_prio: expected %0d, got %0d", want.head_prio, head_prio);
            fail_count++;
          end
          if (count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count);
            fail_count++;
          end
          if (is_empty !== want.is_empty) begin
            $error("is_empty: expected %0b, got %0b", want.is_empty, is_empty);
            fail_count++;
          end
          if (error !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, error);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) expected_heads.push_back(apply_command(cmd, elem, prio));
    end
    pending = expected_heads.size();
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives push and pop words into the priority stack unit under random gaps
// and result-side stalls; a checker beside the block predicts every result
// word and counts mismatches, this top makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module testbench;
  import psu_pkg::*;

  localparam int DEPTH           = 16;
  localparam int ELEM_BITS       = 32;
  localparam int PRIO_BITS       = 8;
  localparam int PHASES          = 17;
  localparam int WORDS_PER_PHASE = 100;
  // long receiver hold-off so the block backs up and stalls its input
  localparam int HOLD_CYCLES     = 200;
  // cycles allowed for outstanding results to drain at the end
  localparam int DRAIN_LIMIT     = 20000;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic                   cmd       = CMD_PUSH;
  logic [ELEM_BITS-1:0]   elem      = '0;
  logic [PRIO_BITS-1:0]   prio      = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [ELEM_BITS-1:0]   head_elem;
  logic [PRIO_BITS-1:0]   head_prio;
  logic [COUNT_BITS-1:0]  count;
  logic                   is_empty;
  logic [1:0]             error;

  int fail_count;
  int pending;

  // phase controls set by the stimulus for the sender and the receiver
  bit sender_gaps = 1'b1;
  bit sink_free   = 1'b0;
  bit hold_req    = 1'b0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  priority_stack_unit #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .elem      (elem),
    .prio      (prio),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head_elem (head_elem),
    .head_prio (head_prio),
    .count     (count),
    .is_empty  (is_empty),
    .error     (error)
  );

  stack_checker #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .elem       (elem),
    .prio       (prio),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .head_elem  (head_elem),
    .head_prio  (head_prio),
    .count      (count),
    .is_empty   (is_empty),
    .error      (error),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // offer one command word, optionally after an idle gap, and wait until taken
  task automatic send_word(logic c, logic [ELEM_BITS-1:0] e, logic [PRIO_BITS-1:0] p);
    int r;
    int gap;
    gap = 0;
    if (sender_gaps) begin
      r = $urandom_range(0, 99);
      if (r < 65) gap = 0;
      else if (r < 93) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    elem     <= e;
    prio     <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // result side: random stall runs, free-flowing phases and one long hold-off
  initial begin : result_sink
    int r;
    int run_len;
    run_len = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // hold-off counted here while the sender keeps offering words
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
        run_len  = 0;
      end else if (sink_free) begin
        out_stall <= 1'b0;
      end else if (run_len > 0) begin
        run_len--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall <= 1'b0;
          run_len = $urandom_range(0, 5);
        end else if (r < 95) begin
          out_stall <= 1'b1;
          run_len = $urandom_range(0, 3);
        end else begin
          out_stall <= 1'b1;
          run_len = $urandom_range(10, 30);
        end
      end
    end
  end

  // stimulus
  initial begin : command_source
    int                   push_pct;
    int                   prio_style;
    int                   guard;
    logic                 c;
    logic [PRIO_BITS-1:0] p;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // pop on an empty store is flagged and changes nothing
    send_word(CMD_POP, 32'hDEAD_BEEF, 8'hFF);
    // extremes of element and priority
    send_word(CMD_PUSH, '0, '0);
    send_word(CMD_PUSH, '1, '1);
    // equal top priority: newest goes to the head
    send_word(CMD_PUSH, 32'h5A5A_A5A5, 8'hFF);
    // equal lowest priority: goes in front of the older zero entry
    send_word(CMD_PUSH, 32'h0000_0001, 8'h00);
    send_word(CMD_PUSH, 32'h8000_0000, 8'h80);
    send_word(CMD_POP, 32'h1234_5678, 8'h12);
    send_word(CMD_POP, '1, '1);
    // fill to the last slot with a spread of priorities
    for (int i = 0; i < 13; i++) send_word(CMD_PUSH, $urandom, PRIO_BITS'(i * 20));
    // push on a full store is dropped
    send_word(CMD_PUSH, 32'hFFFF_0000, 8'hFF);
    send_word(CMD_POP, '0, '0);

    // random phases, push bias swings the store between empty and full
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 5)
        0: push_pct = 50;
        1: push_pct = 85;
        2: push_pct = 15;
        3: push_pct = 95;
        default: push_pct = 5;
      endcase
      prio_style  = $urandom_range(0, 2);
      sender_gaps = (ph % 4 != 1);
      sink_free   = (ph % 6 == 2);
      if (ph == 3) begin
        // back-to-back words against a long receiver hold-off
        sender_gaps = 1'b0;
        sink_free   = 1'b0;
        hold_req    = 1'b1;
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        c = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        case (prio_style)
          // narrow range for lots of ties
          0: p = PRIO_BITS'($urandom_range(0, 3));
          1: p = PRIO_BITS'($urandom);
          default: p = $urandom_range(0, 1) ? '1 : '0;
        endcase
        send_word(c, $urandom, p);
      end
    end
    in_valid <= 1'b0;
    sink_free = 1'b0;

    // let the checker book the last accepted word before watching the backlog
    @(posedge clk);

    // drain outstanding results, then let the bench idle before the verdict
    guard = 0;
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("[priority_stack_unit] OK");
    end else begin
      $display("[priority_stack_unit] ERROR");
    end
    $finish;
  end

  // run limit, well above the slowest legal run
  initial begin : watchdog
    #4000000;
    $display("[priority_stack_unit] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
design/psu_pkg.sv
design/psu_cell.sv
design/priority_stack_unit.sv
design/psu_check.sv
sim/stack_checker.sv
sim/testbench.sv
